[rtl/btbs_pkg.sv]
// Shared types and constants for the bump-texture blend shader.
// No dependencies; it is imported by the top level, blend back end, checker and testbench.
package btbs_pkg;

    localparam int TEX_DIM_MAX_DEF = 256;
    localparam int CFG_IDX_W       = 3;

    // Config register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENCY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT   = 3'd4;

    // Input word commands.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SHADE = 1'b1;

    // One word handed from the texel fetch to the blend back end.
    typedef struct packed {
        logic             pass;   // result is col/alpha as given, no blending
        logic [23:0]      col;    // R in [23:16], G in [15:8], B in [7:0]
        logic [7:0]       alpha;
        logic [7:0]       fx;
        logic [7:0]       fy;
        logic [3:0][23:0] tex;    // texels at (x,y), (x+1,y), (x,y+1), (x+1,y+1)
    } t_bk_in;

endpackage

[rtl/bump_texture_blend_shader.sv]
// Top level of the bump-texture blend shader: config registers, address pipeline,
// texture store with its fetch sequencer. Depends on btbs_pkg and btbs_blend.
//
//  channel   valid         ready          payload
//  input     i_in_valid    o_in_ready     i_cmd, i_texel_index, i_out_x/y, color, occupied
//  output    o_out_valid   i_out_ready    o_out_red/green/blue/alpha
//  config    i_cfg_valid   o_cfg_ready    i_cfg_index, i_cfg_data
//
// In the fetch stage a texel load makes at most one write and a flat or unoccupied pixel
// no store access; a textured pixel makes four reads, one for each bilinear texel, from
// the single-port texture store, and a flat or unoccupied pixel right behind it waits
// while the fourth texel lands in the hand-off stage.
// A result word is offered once its input word has passed the address pipeline, the
// fetch stage, the hand-off stage and the blend back end.
// Reset is synchronous, clears control state and sets the config registers to their
// defaults; the texture store is not cleared. Any stall on the output backs up
// through every stage by the valid/ready chain, so no word is dropped or repeated.
module bump_texture_blend_shader
    import btbs_pkg::*;
#(
    parameter int TEX_DIM_MAX = TEX_DIM_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_cmd,
    input  logic [15:0]          i_texel_index,
    input  logic [11:0]          i_out_x,
    input  logic [11:0]          i_out_y,
    input  logic [7:0]           i_red,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_blue,
    input  logic [7:0]           i_alpha,
    input  logic                 i_occupied,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_red,
    output logic [7:0]           o_out_green,
    output logic [7:0]           o_out_blue,
    output logic [7:0]           o_out_alpha,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0]          i_cfg_data
);

    localparam int DEPTH = TEX_DIM_MAX * TEX_DIM_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int NF    = 7;     // address pipeline stages

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_PASS = 2'd1;
    localparam logic [1:0] KIND_TEX  = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [15:0]         idx;
        logic [23:0]         col;
        logic [7:0]          alpha;
        logic [11:0]         ox;
        logic [11:0]         oy;
        logic [19:0]         xi;
        logic [19:0]         yi;
        logic [7:0]          fx;
        logic [7:0]          fy;
        logic [8:0]          rx;
        logic [8:0]          ry;
        logic [3:0][AW-1:0]  addr;
    } t_fe;

    // ---------------------------------------------------------------------------------
    // Configuration registers. The port never stalls.
    // ---------------------------------------------------------------------------------
    logic        r_tex_mode;
    logic [7:0]  r_transp;
    logic [23:0] r_step;
    logic [8:0]  r_tex_w;
    logic [8:0]  r_tex_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_mode <= 1'b1;
            r_transp   <= 8'd0;
            r_step     <= 24'd819200;
            r_tex_w    <= 9'd256;
            r_tex_h    <= 9'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TEXTURE_MODE: r_tex_mode <= i_cfg_data[0];
                CFG_TRANSPARENCY: r_transp   <= i_cfg_data[7:0];
                CFG_SAMPLE_STEP:  r_step     <= i_cfg_data;
                CFG_TEX_WIDTH:    r_tex_w    <= i_cfg_data[8:0];
                CFG_TEX_HEIGHT:   r_tex_h    <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // A size of zero acts as one, and a size beyond the store acts as its edge.
    logic [8:0] w_c;
    logic [8:0] h_c;

    always_comb begin
        w_c = r_tex_w;
        h_c = r_tex_h;
        if (r_tex_w == 9'd0) begin
            w_c = 9'd1;
        end else if (32'(r_tex_w) > TEX_DIM_MAX) begin
            w_c = 9'(TEX_DIM_MAX);
        end
        if (r_tex_h == 9'd0) begin
            h_c = 9'd1;
        end else if (32'(r_tex_h) > TEX_DIM_MAX) begin
            h_c = 9'(TEX_DIM_MAX);
        end
    end

    // Five restoring remainder steps, one per incoming bit, most significant first.
    function automatic logic [8:0] rem5(input logic [8:0] r, input logic [4:0] b,
                                        input logic [8:0] m);
        logic [9:0] t;
        logic [8:0] q;
        q = r;
        for (int i = 4; i >= 0; i--) begin
            t = {q, b[i]};
            if (t >= {1'b0, m}) begin
                t = t - {1'b0, m};
            end
            q = t[8:0];
        end
        return q;
    endfunction

    // ---------------------------------------------------------------------------------
    // Address pipeline. Stage 0 registers the word, stage 1 scales the coordinates,
    // stages 2 to 5 reduce the integer parts modulo the texture size five bits at a
    // time, and stage 6 forms the four texel addresses.
    // ---------------------------------------------------------------------------------
    logic [NF-1:0] r_fv;
    t_fe           r_fe [NF];
    t_fe           n_fe [NF];
    logic [NF:0]   f_take;
    logic [NF-1:0] f_go;
    logic          m_take;

    always_comb begin
        f_take[NF] = m_take;
        for (int k = NF - 1; k >= 0; k--) begin
            f_go[k]   = r_fv[k] && f_take[k + 1];
            f_take[k] = !r_fv[k] || f_go[k];
        end
    end

    assign o_in_ready = f_take[0];

    always_comb begin
        logic [35:0] px;
        logic [35:0] py;
        logic [9:0]  nx;
        logic [9:0]  ny;
        logic [19:0] row0;
        logic [19:0] row1;
        for (int k = 0; k < NF; k++) begin
            n_fe[k] = (k == 0) ? '0 : r_fe[k - 1];
        end

        n_fe[0].idx   = i_texel_index;
        n_fe[0].ox    = i_out_x;
        n_fe[0].oy    = i_out_y;
        n_fe[0].col   = {i_red, i_green, i_blue};
        n_fe[0].alpha = i_alpha;
        if (i_cmd == CMD_LOAD) begin
            n_fe[0].kind = KIND_LOAD;
        end else if (!i_occupied) begin
            n_fe[0].kind  = KIND_PASS;
            n_fe[0].col   = '0;
            n_fe[0].alpha = '0;
        end else if (!r_tex_mode) begin
            n_fe[0].kind = KIND_PASS;
        end else begin
            n_fe[0].kind = KIND_TEX;
        end

        px = 36'(r_fe[0].ox) * 36'(r_step);
        py = 36'(r_fe[0].oy) * 36'(r_step);
        n_fe[1].xi = px[35:16];
        n_fe[1].yi = py[35:16];
        n_fe[1].fx = px[15:8];
        n_fe[1].fy = py[15:8];
        n_fe[1].rx = '0;
        n_fe[1].ry = '0;

        for (int k = 2; k < 6; k++) begin
            n_fe[k].rx = rem5(r_fe[k - 1].rx, r_fe[k - 1].xi[19 - 5 * (k - 2) -: 5], w_c);
            n_fe[k].ry = rem5(r_fe[k - 1].ry, r_fe[k - 1].yi[19 - 5 * (k - 2) -: 5], h_c);
        end

        nx   = (10'(r_fe[5].rx) + 10'd1 == 10'(w_c)) ? 10'd0 : 10'(r_fe[5].rx) + 10'd1;
        ny   = (10'(r_fe[5].ry) + 10'd1 == 10'(h_c)) ? 10'd0 : 10'(r_fe[5].ry) + 10'd1;
        row0 = 20'(r_fe[5].ry) * 20'(w_c);
        row1 = 20'(ny) * 20'(w_c);
        n_fe[6].addr[0] = AW'(row0 + 20'(r_fe[5].rx));
        n_fe[6].addr[1] = AW'(row0 + 20'(nx));
        n_fe[6].addr[2] = AW'(row1 + 20'(r_fe[5].rx));
        n_fe[6].addr[3] = AW'(row1 + 20'(nx));
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NF; k++) begin
            if (!i_rst_n) begin
                r_fv[k] <= 1'b0;
            end else if (f_take[k]) begin
                r_fv[k] <= (k == 0) ? i_in_valid : f_go[k - 1];
            end
            if (f_take[k]) begin
                r_fe[k] <= n_fe[k];
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Fetch stage. A load writes the store if its index is in range, and ends here.
    // A textured pixel reads its four texels in order, the last once the hand-off
    // stage takes the pixel; the first two are caught here from the read register,
    // the third passes on, and the hand-off stage takes the fourth in the next cycle.
    // ---------------------------------------------------------------------------------
    logic [23:0]   mem [DEPTH];
    logic [23:0]   r_rd;
    logic          r_mv;
    t_fe           r_m;
    logic [1:0]    r_mcnt;
    logic [23:0]   r_mtex0;
    logic [23:0]   r_mtex1;
    logic          m_done;
    logic          m_we;
    logic          m_re;
    logic [AW-1:0] m_addr;
    logic          c_take;

    always_comb begin
        m_done = 1'b0;
        if (r_mv) begin
            unique case (r_m.kind)
                KIND_LOAD: m_done = 1'b1;
                KIND_PASS: m_done = c_take;
                KIND_TEX:  m_done = (r_mcnt == 2'd3) && c_take;
                default:   m_done = 1'b1;
            endcase
        end
    end

    assign m_take = !r_mv || m_done;
    assign m_we   = r_mv && (r_m.kind == KIND_LOAD) && (32'(r_m.idx) < DEPTH);
    assign m_re   = r_mv && (r_m.kind == KIND_TEX) && ((r_mcnt != 2'd3) || m_done);
    assign m_addr = (r_m.kind == KIND_LOAD) ? AW'(r_m.idx) : r_m.addr[r_mcnt];

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            mem[m_addr] <= r_m.col;
        end
        if (m_re) begin
            r_rd <= mem[m_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv   <= 1'b0;
            r_mcnt <= 2'd0;
        end else if (m_take) begin
            r_mv   <= f_go[NF - 1];
            r_mcnt <= 2'd0;
        end else if (r_m.kind == KIND_TEX && r_mcnt != 2'd3) begin
            r_mcnt <= r_mcnt + 2'd1;
        end
        if (m_take) begin
            r_m <= r_fe[NF - 1];
        end
        if (r_mv && r_m.kind == KIND_TEX && r_mcnt == 2'd1) begin
            r_mtex0 <= r_rd;
        end
        if (r_mv && r_m.kind == KIND_TEX && r_mcnt == 2'd2) begin
            r_mtex1 <= r_rd;
        end
    end

    // ---------------------------------------------------------------------------------
    // Hand-off stage toward the blend back end.
    // ---------------------------------------------------------------------------------
    logic   r_cv;
    logic   r_cneed;
    t_bk_in r_c;
    logic   c_go;
    logic   b_ready;

    assign c_go   = r_cv && !r_cneed && b_ready;
    assign c_take = !r_cv || c_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv    <= 1'b0;
            r_cneed <= 1'b0;
        end else if (c_take) begin
            r_cv    <= m_done && (r_m.kind != KIND_LOAD);
            r_cneed <= m_done && (r_m.kind == KIND_TEX);
        end else if (r_cneed) begin
            r_cneed <= 1'b0;
        end
        if (c_take) begin
            r_c.pass   <= (r_m.kind != KIND_TEX);
            r_c.col    <= r_m.col;
            r_c.alpha  <= r_m.alpha;
            r_c.fx     <= r_m.fx;
            r_c.fy     <= r_m.fy;
            r_c.tex[0] <= r_mtex0;
            r_c.tex[1] <= r_mtex1;
            r_c.tex[2] <= r_rd;
            r_c.tex[3] <= r_rd;
        end else if (r_cneed) begin
            r_c.tex[3] <= r_rd;
        end
    end

    btbs_blend u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_cv && !r_cneed),
        .o_ready        (b_ready),
        .i_word         (r_c),
        .i_transparency (r_transp),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_red          (o_out_red),
        .o_green        (o_out_green),
        .o_blue         (o_out_blue),
        .o_alpha        (o_out_alpha)
    );

endmodule

[rtl/btbs_blend.sv]
// Blend back end: bilinear filter, multiply blend, transparency mix, rounding.
// Depends on btbs_pkg for the input word type.
module btbs_blend
    import btbs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_bk_in       i_word,
    input  logic [7:0]   i_transparency,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [7:0]   o_red,
    output logic [7:0]   o_green,
    output logic [7:0]   o_blue,
    output logic [7:0]   o_alpha
);

    localparam int NST = 6;

    typedef struct packed {
        logic             pass;
        logic [2:0][7:0]  col;    // element 0 is red
        logic [7:0]       alpha;
        logic [7:0]       fy;
        logic [2:0][15:0] bot;
        logic [2:0][15:0] top;
        logic [2:0][7:0]  s;
        logic [2:0][16:0] rb;
        logic [2:0][25:0] n;
        logic [2:0][17:0] u;
        logic [2:0][10:0] q0;
        logic [2:0][7:0]  res;
    } t_bs;

    function automatic logic [15:0] lerp(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] f);
        logic [16:0] v;
        v = 17'(a) * (17'd256 - 17'(f)) + 17'(b) * 17'(f);
        return v[15:0];
    endfunction

    function automatic logic [7:0] bilin(input logic [15:0] bt, input logic [15:0] tp,
                                         input logic [7:0] f);
        logic [24:0] sum;
        logic [8:0]  sr;
        sum = 25'(bt) * (25'd256 - 25'(f)) + 25'(tp) * 25'(f);
        sum = sum + 25'd32768;
        sr  = sum[24:16];
        return (sr > 9'd255) ? 8'd255 : sr[7:0];
    endfunction

    // Multiply blend scaled by 255; always within 0..65025.
    function automatic logic [16:0] mblend(input logic [7:0] c, input logic [7:0] s);
        logic signed [19:0] ci;
        logic signed [19:0] si;
        logic signed [19:0] r;
        ci = 20'(c);
        si = 20'(s);
        if (s <= 8'd127) begin
            r = 20'sd2 * ci * si;
        end else begin
            r = 20'sd255 * ci + (si - ci) * (20'sd2 * si - 20'sd255);
        end
        return r[16:0];
    endfunction

    function automatic logic [25:0] tmix(input logic [7:0] c, input logic [16:0] rb,
                                         input logic [7:0] t);
        logic signed [27:0] ci;
        logic signed [27:0] ri;
        logic signed [27:0] ti;
        logic signed [27:0] n;
        ci = 28'(c);
        ri = 28'(rb);
        ti = 28'(t);
        n  = 28'sd65280 * ci + (ri - 28'sd255 * ci) * (28'sd256 - ti);
        if (n < 0) begin
            n = '0;
        end
        return n[25:0];
    endfunction

    logic [NST-1:0] r_bv;
    t_bs            r_bs [NST];
    t_bs            n_bs [NST];
    logic [NST:0]   b_take;
    logic [NST-1:0] b_go;

    always_comb begin
        b_take[NST] = i_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            b_go[k]   = r_bv[k] && b_take[k + 1];
            b_take[k] = !r_bv[k] || b_go[k];
        end
    end

    assign o_ready = b_take[0];

    always_comb begin
        logic [32:0] prod;
        logic [25:0] m;
        logic [18:0] rm;
        logic [10:0] q;
        for (int k = 0; k < NST; k++) begin
            n_bs[k] = (k == 0) ? '0 : r_bs[k - 1];
        end
        // Stage 0: horizontal lerps.
        n_bs[0].pass  = i_word.pass;
        n_bs[0].alpha = i_word.alpha;
        n_bs[0].fy    = i_word.fy;
        for (int i = 0; i < 3; i++) begin
            n_bs[0].col[i] = i_word.col[16 - 8 * i +: 8];
            n_bs[0].bot[i] = lerp(i_word.tex[0][16 - 8 * i +: 8],
                                  i_word.tex[1][16 - 8 * i +: 8], i_word.fx);
            n_bs[0].top[i] = lerp(i_word.tex[2][16 - 8 * i +: 8],
                                  i_word.tex[3][16 - 8 * i +: 8], i_word.fx);
        end
        for (int i = 0; i < 3; i++) begin
            // Stage 1: vertical lerp and rounding to 8 bits.
            n_bs[1].s[i]  = bilin(r_bs[0].bot[i], r_bs[0].top[i], r_bs[0].fy);
            // Stage 2: multiply blend.
            n_bs[2].rb[i] = mblend(r_bs[1].col[i], r_bs[1].s[i]);
            // Stage 3: mix back toward the structure color.
            n_bs[3].n[i]  = tmix(r_bs[2].col[i], r_bs[2].rb[i], i_transparency);
            // Stage 4: n/65280 = ((n+32640)>>8)/255, estimated by reciprocal.
            m             = r_bs[3].n[i] + 26'd32640;
            n_bs[4].u[i]  = m[25:8];
            prod          = 33'(m[25:8]) * 33'd16448;
            n_bs[4].q0[i] = prod[32:22];
            // Stage 5: one correction step and saturation; a pass word keeps its color.
            rm            = 19'(r_bs[4].u[i]) - 19'(r_bs[4].q0[i]) * 19'd255;
            q             = r_bs[4].q0[i] + ((rm >= 19'd255) ? 11'd1 : 11'd0);
            if (r_bs[4].pass) begin
                n_bs[5].res[i] = r_bs[4].col[i];
            end else begin
                n_bs[5].res[i] = (q > 11'd255) ? 8'd255 : q[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (!i_rst_n) begin
                r_bv[k] <= 1'b0;
            end else if (b_take[k]) begin
                r_bv[k] <= (k == 0) ? i_valid : b_go[k - 1];
            end
            if (b_take[k]) begin
                r_bs[k] <= n_bs[k];
            end
        end
    end

    assign o_valid = r_bv[NST - 1];
    assign o_red   = r_bs[NST - 1].res[0];
    assign o_green = r_bs[NST - 1].res[1];
    assign o_blue  = r_bs[NST - 1].res[2];
    assign o_alpha = r_bs[NST - 1].alpha;

endmodule

[rtl/btbs_checker.sv]
// Port-level checks for the bump-texture blend shader, bound to the top level.
// Depends on btbs_pkg for the config index width.
module btbs_checker
    import btbs_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 i_cmd,
    input logic [15:0]          i_texel_index,
    input logic [11:0]          i_out_x,
    input logic [11:0]          i_out_y,
    input logic [7:0]           i_red,
    input logic [7:0]           i_green,
    input logic [7:0]           i_blue,
    input logic [7:0]           i_alpha,
    input logic                 i_occupied,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [7:0]           o_out_red,
    input logic [7:0]           o_out_green,
    input logic [7:0]           o_out_blue,
    input logic [7:0]           o_out_alpha,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [23:0]          i_cfg_data
);

    // A result word stays offered until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word withdrawn before it was taken");

    // A stalled result word keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_red) && $stable(o_out_green)
            && $stable(o_out_blue) && $stable(o_out_alpha))
        else $error("result word changed while stalled");

    // Reset empties the whole pipeline, so no result word is offered right after it.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word offered right after reset");

    // After reset the input side is ready at once.
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && o_cfg_ready)
        else $error("not ready right after reset");

endmodule

bind bump_texture_blend_shader btbs_checker u_btbs_checker (.*);

[tb/bump_texture_blend_shader_tb.sv]
// Self-checking testbench for the bump-texture blend shader: random valid/ready traffic,
// an in-bench bilinear sample and multiply-blend predictor, and a config register sweep.
// Depends on btbs_pkg and the bump_texture_blend_shader RTL.
`timescale 1ns / 100ps

module bump_texture_blend_shader_tb;
    import btbs_pkg::*;

    localparam int TEX_DIM    = 256;
    localparam int STORE_SIZE = TEX_DIM * TEX_DIM;
    localparam int WATCHDOG_LIMIT = 4000;
    // Margin after the last pixel, since a trailing texel load has no result to wait on.
    localparam int DRAIN_CYCLES = 32;

    // An index that names no register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic        cmd;
        logic [15:0] idx;
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic        occ;
    } t_pix_word;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_rgba;

    localparam int PIX_W = $bits(t_pix_word);

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_pix_word            in_word = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [7:0]           o_out_red, o_out_green, o_out_blue, o_out_alpha;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [23:0]          i_cfg_data = '0;

    bump_texture_blend_shader u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (in_word.cmd),
        .i_texel_index (in_word.idx),
        .i_out_x       (in_word.x),
        .i_out_y       (in_word.y),
        .i_red         (in_word.r),
        .i_green       (in_word.g),
        .i_blue        (in_word.b),
        .i_alpha       (in_word.a),
        .i_occupied    (in_word.occ),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_alpha   (o_out_alpha),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the config registers, updated when a config word is accepted.
    logic        mode_q   = 1'b1;
    logic [7:0]  transp_q = 8'd0;
    logic [23:0] step_q   = 24'd819200;
    logic [8:0]  width_q  = 9'd256;
    logic [8:0]  height_q = 9'd256;

    // Texture contents as the block sees them (updated on acceptance), and the set of
    // texels already queued for loading, which the stimulus uses to avoid unwritten reads.
    logic [23:0] texels_seen [STORE_SIZE];
    bit          texel_queued [STORE_SIZE];

    t_pix_word pending_words[$];
    t_rgba     expected_pixels[$];
    int        mismatches = 0;
    bit        no_idle = 1'b0;
    int        in_gap = 0;
    int        out_gap = 0;
    int        quiet_cycles = 0;

    function automatic int clamp_dim(logic [8:0] d);
        if (d == 0) return 1;
        if (d > TEX_DIM) return TEX_DIM;
        return int'(d);
    endfunction

    // Computes the four bilinear texel addresses and the fractions for one pixel.
    task automatic footprint(input logic [11:0] ox, input logic [11:0] oy,
                             output int addr[4], output int fx, output int fy);
        longint px, py;
        int w, h, ix, iy, nx, ny;
        w  = clamp_dim(width_q);
        h  = clamp_dim(height_q);
        px = longint'(ox) * longint'(step_q);
        py = longint'(oy) * longint'(step_q);
        ix = int'((px >> 16) % w);
        iy = int'((py >> 16) % h);
        fx = int'((px >> 8) & 255);
        fy = int'((py >> 8) & 255);
        nx = (ix + 1 == w) ? 0 : ix + 1;
        ny = (iy + 1 == h) ? 0 : iy + 1;
        addr[0] = ix + iy * w;
        addr[1] = nx + iy * w;
        addr[2] = ix + ny * w;
        addr[3] = nx + ny * w;
    endtask

    // Bidirectional multiply of color c by sample s, the blend weighted by (1 - t) and c by t.
    function automatic logic [7:0] multiply_blend(int c, int s, int t);
        longint r, n, q;
        if (s <= 127) r = 2 * c * s;
        else r = 255 * c + longint'(s - c) * (2 * s - 255);
        n = 65280 * longint'(c) + (r - 255 * c) * (256 - t);
        if (n < 0) n = 0;
        q = (n + 32640) / 65280;
        if (q > 255) q = 255;
        return q[7:0];
    endfunction

    // Works out the shaded pixel for an accepted word, or records the texel it loads.
    task automatic shade_predict(input t_pix_word wd);
        t_rgba res;
        int addr[4];
        int fx, fy, sh, bot, top, s;
        longint sum;
        logic [7:0] col[3];
        if (wd.cmd == CMD_LOAD) begin
            texels_seen[wd.idx] = {wd.r, wd.g, wd.b};
            return;
        end
        col = '{wd.r, wd.g, wd.b};
        if (!wd.occ) begin
            res = '0;
        end else if (!mode_q) begin
            res = {wd.r, wd.g, wd.b, wd.a};
        end else begin
            footprint(wd.x, wd.y, addr, fx, fy);
            for (int i = 0; i < 3; i++) begin
                sh  = 16 - 8 * i;
                bot = int'(texels_seen[addr[0]][sh +: 8]) * (256 - fx)
                    + int'(texels_seen[addr[1]][sh +: 8]) * fx;
                top = int'(texels_seen[addr[2]][sh +: 8]) * (256 - fx)
                    + int'(texels_seen[addr[3]][sh +: 8]) * fx;
                sum = longint'(bot) * (256 - fy) + longint'(top) * fy;
                s   = int'((sum + 32768) >> 16);
                if (s > 255) s = 255;
                col[i] = multiply_blend(int'(col[i]), s, int'(transp_q));
            end
            res = {col[0], col[1], col[2], wd.a};
        end
        expected_pixels.push_back(res);
    endtask

    task automatic queue_load(input int idx, input logic [23:0] rgb);
        t_pix_word wd;
        wd     = t_pix_word'(PIX_W'({$urandom, $urandom, $urandom}));
        wd.cmd = CMD_LOAD;
        wd.idx = idx[15:0];
        {wd.r, wd.g, wd.b} = rgb;
        texel_queued[idx] = 1'b1;
        pending_words.push_back(wd);
    endtask

    // Queues a shade word, first loading any of its texels not yet written
    // (and now and then rewriting one that was, to move the sample around).
    task automatic queue_shade(input logic [11:0] x, input logic [11:0] y,
                               input logic [31:0] rgba, input logic occ);
        t_pix_word wd;
        int addr[4];
        int fx, fy;
        if (occ && mode_q) begin
            footprint(x, y, addr, fx, fy);
            for (int k = 0; k < 4; k++)
                if (!texel_queued[addr[k]] || $urandom_range(0, 3) == 0)
                    queue_load(addr[k], 24'($urandom));
        end
        wd     = t_pix_word'(PIX_W'({$urandom, $urandom, $urandom}));
        wd.cmd = CMD_SHADE;
        wd.x   = x;
        wd.y   = y;
        {wd.r, wd.g, wd.b, wd.a} = rgba;
        wd.occ = occ;
        pending_words.push_back(wd);
    endtask

    // Presents one config word and waits for it to be taken; the caller drops valid
    // once its last write is done.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TEXTURE_MODE: mode_q   = data[0];
            CFG_TRANSPARENCY: transp_q = data[7:0];
            CFG_SAMPLE_STEP:  step_q   = data;
            CFG_TEX_WIDTH:    width_q  = data[8:0];
            CFG_TEX_HEIGHT:   height_q = data[8:0];
            default: ;
        endcase
    endtask

    // Waits until every queued word is taken and every expected pixel has come back,
    // then lets the pipeline empty of trailing texel loads.
    task automatic drain;
        while (pending_words.size() != 0 || i_in_valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic mode, input logic [7:0] transp,
                             input logic [23:0] step, input logic [8:0] w,
                             input logic [8:0] h, input int n_words);
        logic [11:0] x, y;
        cfg_write(CFG_TEXTURE_MODE, 24'(mode));
        cfg_write(CFG_TRANSPARENCY, 24'(transp));
        cfg_write(CFG_SAMPLE_STEP, step);
        cfg_write(CFG_TEX_WIDTH, 24'(w));
        cfg_write(CFG_TEX_HEIGHT, 24'(h));
        cfg_write(CFG_SPARE, 24'($urandom));
        i_cfg_valid <= 1'b0;
        for (int n = 0; n < n_words; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                // Stray texel load anywhere in the store.
                queue_load($urandom_range(0, STORE_SIZE - 1), 24'($urandom));
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    x = 12'($urandom_range(0, 15));
                    y = 12'($urandom_range(0, 15));
                end else begin
                    x = 12'($urandom);
                    y = 12'($urandom);
                end
                queue_shade(x, y, $urandom, $urandom_range(0, 7) != 0);
            end
        end
        drain();
    endtask

    // Input driver: presents words from the pending queue with random idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                shade_predict(in_word);
            if (in_gap > 0)
                in_gap--;
            if (!i_in_valid || o_in_ready) begin
                if (in_gap == 0 && pending_words.size() != 0) begin
                    in_word    <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    if (!no_idle && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 16);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each pixel word against the oldest expectation,
    // throttles ready in bursts, and runs the watchdog.
    always @(posedge i_clk) begin
        t_rgba want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel word r=%0d g=%0d b=%0d a=%0d",
                           o_out_red, o_out_green, o_out_blue, o_out_alpha);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_out_red !== want.r) begin
                        $error("out_red expected %0d actual %0d", want.r, o_out_red);
                        mismatches++;
                    end
                    if (o_out_green !== want.g) begin
                        $error("out_green expected %0d actual %0d", want.g, o_out_green);
                        mismatches++;
                    end
                    if (o_out_blue !== want.b) begin
                        $error("out_blue expected %0d actual %0d", want.b, o_out_blue);
                        mismatches++;
                    end
                    if (o_out_alpha !== want.a) begin
                        $error("out_alpha expected %0d actual %0d", want.a, o_out_alpha);
                        mismatches++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0)
                    out_gap = $urandom_range(1, 16);
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset settings: corner pixels, color extremes,
        // an unoccupied pixel and texel loads at both ends of the store.
        queue_load(0, 24'hFFFFFF);
        queue_load(STORE_SIZE - 1, 24'h000000);
        queue_shade(12'd0, 12'd0, 32'h00000000, 1'b1);
        queue_shade(12'd4095, 12'd4095, 32'hFFFFFFFF, 1'b1);
        queue_shade(12'd1, 12'd2, 32'h807F10EF, 1'b1);
        queue_shade(12'd4095, 12'd0, 32'hFFFFFFFF, 1'b0);
        queue_shade(12'd0, 12'd4095, 32'h7F80FF00, 1'b1);
        drain();

        // Setting sweep: extremes of every register, including sizes of zero and
        // sizes past the texture limit, then random settings.
        run_phase(1'b1, 8'd0, 24'hFFFFFF, 9'd256, 9'd256, 16);
        run_phase(1'b1, 8'd255, 24'd0, 9'd1, 9'd1, 12);
        run_phase(1'b0, 8'd128, 24'($urandom), 9'd511, 9'd0, 16);
        run_phase(1'b1, 8'd77, 24'($urandom), 9'd0, 9'd511, 20);
        for (int p = 0; p < 5; p++)
            run_phase(1'b1, 8'($urandom), 24'($urandom_range(0, 24'h3FFFF)),
                      9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)), 24);
        run_phase(1'b1, 8'($urandom), 24'($urandom), 9'($urandom_range(1, 300)),
                  9'($urandom_range(1, 300)), 24);
        no_idle = 1'b1;
        run_phase(1'b1, 8'($urandom), 24'($urandom), 9'($urandom_range(1, 40)),
                  9'($urandom_range(1, 40)), 24);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
rtl/btbs_pkg.sv
rtl/btbs_blend.sv
rtl/bump_texture_blend_shader.sv
rtl/btbs_checker.sv
tb/bump_texture_blend_shader_tb.sv
